// File: rtl/core/chc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_pkg
// Types, constants and the control store for the canonical code assigner.
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int unsigned COUNT_SLOTS = 16;
  localparam int unsigned CountIdxW   = 4;
  localparam int unsigned LenW        = 5;
  localparam int unsigned CodeW       = 17;
  localparam int unsigned UpcW        = 3;

  typedef logic [UpcW-1:0] upc_t;

  // step addresses of the control program
  localparam upc_t STEP_WAIT  = 3'd0;
  localparam upc_t STEP_LOAD  = 3'd1;
  localparam upc_t STEP_CLEAR = 3'd2;
  localparam upc_t STEP_ADV   = 3'd3;
  localparam upc_t STEP_EMIT  = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD_COUNT = 2'd0,
    OP_ASSIGN     = 2'd1,
    OP_NEW_TABLE  = 2'd2,
    OP_UNUSED     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_LENGTH = 2'd1,
    ST_EXHAUSTED = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CLEAR,
    ACT_ADV,
    ACT_EMIT
  } act_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_REQ,
    COND_NEED_ADV,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic  in_ready;
    act_e  act;
    cond_e cond;
    upc_t  jmp_t;
    upc_t  jmp_f;
  } ctrl_t;

  typedef struct packed {
    logic need_adv;
    logic out_busy;
  } dp_stat_t;

  // control store: one word per step
  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    w = '{in_ready: 1'b0, act: ACT_NONE, cond: COND_ALWAYS,
          jmp_t: STEP_WAIT, jmp_f: STEP_WAIT};
    case (pc)
      STEP_WAIT: begin
        w = '{in_ready: 1'b1, act: ACT_NONE, cond: COND_REQ,
              jmp_t: STEP_WAIT, jmp_f: STEP_WAIT};
      end
      STEP_LOAD: begin
        w = '{in_ready: 1'b0, act: ACT_LOAD, cond: COND_ALWAYS,
              jmp_t: STEP_WAIT, jmp_f: STEP_WAIT};
      end
      STEP_CLEAR: begin
        w = '{in_ready: 1'b0, act: ACT_CLEAR, cond: COND_ALWAYS,
              jmp_t: STEP_WAIT, jmp_f: STEP_WAIT};
      end
      STEP_ADV: begin
        w = '{in_ready: 1'b0, act: ACT_ADV, cond: COND_NEED_ADV,
              jmp_t: STEP_ADV, jmp_f: STEP_EMIT};
      end
      STEP_EMIT: begin
        w = '{in_ready: 1'b0, act: ACT_EMIT, cond: COND_OUT_BUSY,
              jmp_t: STEP_EMIT, jmp_f: STEP_WAIT};
      end
      default: begin
        w = '{in_ready: 1'b0, act: ACT_NONE, cond: COND_ALWAYS,
              jmp_t: STEP_WAIT, jmp_f: STEP_WAIT};
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/chc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_seq
// Step counter and control store; dispatches each request by its opcode.
// ----------------------------------------------------------------------------
module chc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_accept_i,
  input  logic [1:0]        opcode_i,
  input  chc_pkg::dp_stat_t stat_i,
  output chc_pkg::ctrl_t    ctrl_o
);

  chc_pkg::upc_t  pc_q, pc_d;
  chc_pkg::ctrl_t word;

  function automatic chc_pkg::upc_t dispatch(logic [1:0] op);
    chc_pkg::upc_t t;
    case (op)
      chc_pkg::OP_LOAD_COUNT: t = chc_pkg::STEP_LOAD;
      chc_pkg::OP_ASSIGN:     t = chc_pkg::STEP_ADV;
      chc_pkg::OP_NEW_TABLE:  t = chc_pkg::STEP_CLEAR;
      default:                t = chc_pkg::STEP_WAIT;
    endcase
    return t;
  endfunction

  assign word   = chc_pkg::ucode(pc_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      chc_pkg::COND_ALWAYS:   pc_d = word.jmp_t;
      chc_pkg::COND_REQ:      pc_d = in_accept_i ? dispatch(opcode_i) : word.jmp_f;
      chc_pkg::COND_NEED_ADV: pc_d = stat_i.need_adv ? word.jmp_t : word.jmp_f;
      chc_pkg::COND_OUT_BUSY: pc_d = stat_i.out_busy ? word.jmp_t : word.jmp_f;
      default:                pc_d = chc_pkg::STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= chc_pkg::STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  // a symbol step that finds the output free returns to the request wait
  a_emit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == chc_pkg::STEP_EMIT && !stat_i.out_busy) |=> pc_q == chc_pkg::STEP_WAIT)
    else $error("emit step did not return to wait");

  a_accept_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i |-> pc_q == chc_pkg::STEP_WAIT)
    else $error("request taken outside wait step");

endmodule

// File: rtl/core/chc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_dp
// Length counts, code counter and result register, driven by the control word.
// ----------------------------------------------------------------------------
module chc_dp #(
  parameter int unsigned MAX_CODE_LENGTH = 16,
  parameter int unsigned SYMBOL_BITS     = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_accept_i,
  input  logic [7:0]        value_i,
  input  chc_pkg::act_e     act_i,
  output chc_pkg::dp_stat_t stat_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        symbol_out_o,
  output logic [15:0]       code_bits_o,
  output logic [4:0]        code_length_o,
  output logic [1:0]        status_o
);

  localparam logic [7:0] SymMask = (SYMBOL_BITS >= 8) ? 8'hFF
                                 : 8'((1 << SYMBOL_BITS) - 1);
  localparam logic [chc_pkg::LenW-1:0] MaxLen = chc_pkg::LenW'(MAX_CODE_LENGTH);

  logic [7:0]                  counts_q [chc_pkg::COUNT_SLOTS];
  logic [7:0]                  counts_d [chc_pkg::COUNT_SLOTS];
  logic [chc_pkg::LenW-1:0]    loaded_q, loaded_d;
  logic [chc_pkg::LenW-1:0]    cur_q, cur_d;
  logic [7:0]                  left_q, left_d;
  logic [chc_pkg::CodeW-1:0]   code_q, code_d;
  logic [7:0]                  value_q;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  sym_q;
  logic [15:0]                 bits_q;
  logic [4:0]                  len_q;
  logic [1:0]                  st_q;

  logic                        need_adv, out_busy, exhausted, emit_fire;
  logic [chc_pkg::CodeW-1:0]   limit;

  assign need_adv  = (left_q == 8'd0) && (cur_q < MaxLen);
  assign out_busy  = out_valid_q & out_stall_i;
  assign limit     = chc_pkg::CodeW'(1) << cur_q;
  assign exhausted = code_q >= limit;
  assign emit_fire = (act_i == chc_pkg::ACT_EMIT) && !out_busy;

  assign stat_o.need_adv = need_adv;
  assign stat_o.out_busy = out_busy;

  always_comb begin
    counts_d = counts_q;
    loaded_d = loaded_q;
    cur_d    = cur_q;
    left_d   = left_q;
    code_d   = code_q;
    case (act_i)
      chc_pkg::ACT_LOAD: begin
        // counts past the sixteenth are dropped
        if (loaded_q < chc_pkg::LenW'(chc_pkg::COUNT_SLOTS)) begin
          counts_d[loaded_q[chc_pkg::CountIdxW-1:0]] = value_q;
          loaded_d = loaded_q + 1'b1;
        end
      end
      chc_pkg::ACT_CLEAR: begin
        for (int i = 0; i < chc_pkg::COUNT_SLOTS; i++) counts_d[i] = 8'd0;
        loaded_d = '0;
        cur_d    = '0;
        left_d   = '0;
        code_d   = '0;
      end
      chc_pkg::ACT_ADV: begin
        // step one length: cur < MaxLen here, so with MAX_CODE_LENGTH <= 16 cur indexes its count
        if (need_adv) begin
          cur_d  = cur_q + 1'b1;
          code_d = code_q << 1;
          left_d = counts_q[cur_q[chc_pkg::CountIdxW-1:0]];
        end
      end
      chc_pkg::ACT_EMIT: begin
        if (!out_busy && left_q != 8'd0) begin
          left_d = left_q - 1'b1;
          if (!exhausted) code_d = code_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < chc_pkg::COUNT_SLOTS; i++) counts_q[i] <= 8'd0;
      loaded_q    <= '0;
      cur_q       <= '0;
      left_q      <= '0;
      code_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      counts_q    <= counts_d;
      loaded_q    <= loaded_d;
      cur_q       <= cur_d;
      left_q      <= left_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      value_q <= value_i;
    end
    if (emit_fire) begin
      sym_q <= value_q & SymMask;
      if (left_q == 8'd0) begin
        bits_q <= 16'd0;
        len_q  <= 5'd0;
        st_q   <= chc_pkg::ST_NO_LENGTH;
      end else if (exhausted) begin
        bits_q <= 16'd0;
        len_q  <= 5'd0;
        st_q   <= chc_pkg::ST_EXHAUSTED;
      end else begin
        bits_q <= code_q[15:0];
        len_q  <= cur_q;
        st_q   <= chc_pkg::ST_OK;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_out_o  = sym_q;
  assign code_bits_o   = bits_q;
  assign code_length_o = len_q;
  assign status_o      = st_q;

  a_code_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_q <= limit)
    else $error("code counter above 2^length");

  a_length_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= MaxLen && loaded_q <= chc_pkg::LenW'(chc_pkg::COUNT_SLOTS))
    else $error("length or count index out of range");

  a_ok_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && st_q == chc_pkg::ST_OK) |-> (len_q != 5'd0 && len_q <= MaxLen))
    else $error("ok result without a legal length");

endmodule

// File: rtl/core/canonical_huffman_code_assigner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_code_assigner_unit
// Assigns canonical codes to symbols from a table given as per-length counts.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | opcode_i, value_i
//  out     | output    | out_valid_o / out_stall_i | symbol_out_o, code_bits_o,
//          |           |                        | code_length_o, status_o
//
// Count and new-table requests go through their load or clear step and back
// to wait; an unused opcode stays in wait. A symbol loops in the length-advance
// step of the control program (at most MAX_CODE_LENGTH lengths), then emits.
// A symbol waits in its emit step while the result register is stalled.
// Reset clears all counts and the code state at once; no clearing pass.
// ----------------------------------------------------------------------------
module canonical_huffman_code_assigner_unit #(
  parameter int unsigned MAX_CODE_LENGTH = 16,
  parameter int unsigned SYMBOL_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  symbol_out_o,
  output logic [15:0] code_bits_o,
  output logic [4:0]  code_length_o,
  output logic [1:0]  status_o
);

  chc_pkg::ctrl_t    ctrl;
  chc_pkg::dp_stat_t stat;
  logic              in_accept;

  assign in_stall_o = ~ctrl.in_ready;
  assign in_accept  = in_valid_i & ctrl.in_ready;

  chc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_accept_i(in_accept),
    .opcode_i   (opcode_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  chc_dp #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .SYMBOL_BITS    (SYMBOL_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .value_i      (value_i),
    .act_i        (ctrl.act),
    .stat_o       (stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .symbol_out_o (symbol_out_o),
    .code_bits_o  (code_bits_o),
    .code_length_o(code_length_o),
    .status_o     (status_o)
  );

endmodule
